// File: src/btlv_pkg.sv
// Shared types, codes and defaults of the BER-TLV stream parser.
package btlv_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_DEPTH_DEF    = 8;
    localparam int MAX_TAG_SCAN_DEF = 10;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int LEVEL_W = 4;
    localparam int TAG_W   = 32;
    localparam int LEN_W   = 24;

    // Header byte decoding
    localparam logic [4:0] TAG_MULTI_CODE = 5'h1F;
    localparam logic [6:0] LEN_MAX_BYTES  = 7'd3;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_VALUE  = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    // Error codes
    typedef enum logic [1:0] {
        ERR_LEN_FORM  = 2'd0,
        ERR_OVERRUN   = 2'd1,
        ERR_DEPTH     = 2'd2,
        ERR_TRUNCATED = 2'd3
    } t_err;

    // Parser phase, one-hot
    typedef enum logic [4:0] {
        PH_TAG_FIRST = 5'b00001,
        PH_TAG_MORE  = 5'b00010,
        PH_LEN_FIRST = 5'b00100,
        PH_LEN_MORE  = 5'b01000,
        PH_VALUE     = 5'b10000
    } t_phase;

    // One result beat
    typedef struct packed {
        t_kind               kind;
        logic [LEVEL_W-1:0]  nest_level;
        logic [TAG_W-1:0]    tag_value;
        logic                is_constructed;
        logic [LEN_W-1:0]    value_length;
        logic [BYTE_W-1:0]   value_byte;
        logic                last_value_byte;
        t_err                error_code;
    } t_result;

    // Error result: everything but kind, level and code is zero
    function automatic t_result make_error(logic [LEVEL_W-1:0] level, t_err code);
        t_result r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.nest_level = level;
        r.error_code = code;
        return r;
    endfunction

endpackage

// File: src/btlv_in_if.sv
// Input channel: one raw stream byte per beat.
interface btlv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// File: src/btlv_out_if.sv
// Output channel: one header, value byte or error per beat.
interface btlv_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  nest_level;
    logic [31:0] tag_value;
    logic        is_constructed;
    logic [23:0] value_length;
    logic [7:0]  value_byte;
    logic        last_value_byte;
    logic [1:0]  error_code;

    modport source (output valid, output kind, output nest_level, output tag_value,
                    output is_constructed, output value_length, output value_byte,
                    output last_value_byte, output error_code, input ready);
    modport sink   (input valid, input kind, input nest_level, input tag_value,
                    input is_constructed, input value_length, input value_byte,
                    input last_value_byte, input error_code, output ready);
endinterface

// File: src/btlv_core.sv
// Parser state, nesting stack and per-byte decode logic.
module btlv_core #(
    parameter int MAX_DEPTH    = btlv_pkg::MAX_DEPTH_DEF,
    parameter int MAX_TAG_SCAN = btlv_pkg::MAX_TAG_SCAN_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic [7:0]              i_data_byte,
    input  logic                    i_end_of_stream,
    output logic                    o_res_valid,
    output btlv_pkg::t_result       o_res
);

    localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int LEN_W = btlv_pkg::LEN_W;

    // Parser state
    btlv_pkg::t_phase   r_phase, n_phase;
    logic [31:0]        r_tag, n_tag;
    logic [3:0]         r_tag_cnt, n_tag_cnt;
    logic               r_cons, n_cons;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [1:0]         r_len_left, n_len_left;
    logic [LEN_W-1:0]   r_vbl, n_vbl;
    logic [3:0]         r_dp, n_dp;
    logic               r_err, n_err;

    // Stack of unclaimed byte counts, one entry per open constructed element
    logic [LEN_W-1:0]   r_stack [MAX_DEPTH];

    logic               has_parent;
    logic [3:0]         dp_m1;
    logic [IDX_W-1:0]   top_idx;
    logic [IDX_W-1:0]   push_idx;
    logic [LEN_W-1:0]   top;
    logic               per_dec;
    logic [LEN_W-1:0]   top_dec;
    logic [LEN_W-1:0]   top_new;
    logic               wr_top;
    logic               wr_push;
    logic [LEN_W-1:0]   hdr_len;
    logic               hdr_fire;
    logic               close_req;
    logic               err_v;
    btlv_pkg::t_err     err_code;
    btlv_pkg::t_result  res;
    logic               res_v;
    logic [3:0]         cdp;
    logic               nz;

    // Top of stack
    assign has_parent = (r_dp != 4'd0);
    assign dp_m1      = r_dp - 4'd1;
    assign top_idx    = dp_m1[IDX_W-1:0];
    assign push_idx   = r_dp[IDX_W-1:0];
    assign top        = has_parent ? r_stack[top_idx] : '0;
    // Every header byte uses up one byte of the enclosing element
    assign per_dec    = has_parent && (r_phase != btlv_pkg::PH_VALUE);
    assign top_dec    = top - LEN_W'(per_dec);

    // Byte decode
    always_comb begin
        n_phase    = r_phase;
        n_tag      = r_tag;
        n_tag_cnt  = r_tag_cnt;
        n_cons     = r_cons;
        n_len      = r_len;
        n_len_left = r_len_left;
        n_vbl      = r_vbl;
        n_dp       = r_dp;
        n_err      = r_err;
        top_new    = top_dec;
        wr_top     = 1'b0;
        wr_push    = 1'b0;
        hdr_fire   = 1'b0;
        hdr_len    = '0;
        close_req  = 1'b0;
        err_v      = 1'b0;
        err_code   = btlv_pkg::ERR_LEN_FORM;
        res        = '0;
        res_v      = 1'b0;
        cdp        = 4'd0;
        nz         = 1'b0;

        if (i_accept && !r_err) begin
            if (per_dec && top == '0) begin
                err_v    = 1'b1;
                err_code = btlv_pkg::ERR_OVERRUN;
            end else begin
                wr_top = per_dec;
                unique case (r_phase)
                    btlv_pkg::PH_TAG_FIRST: begin
                        n_tag     = 32'(i_data_byte);
                        n_tag_cnt = 4'd0;
                        n_cons    = i_data_byte[5];
                        n_phase   = (i_data_byte[4:0] == btlv_pkg::TAG_MULTI_CODE)
                                  ? btlv_pkg::PH_TAG_MORE : btlv_pkg::PH_LEN_FIRST;
                    end
                    btlv_pkg::PH_TAG_MORE: begin
                        n_tag     = {r_tag[23:0], i_data_byte};
                        n_tag_cnt = r_tag_cnt + 4'd1;
                        if (!i_data_byte[7] || n_tag_cnt >= 4'(MAX_TAG_SCAN)) begin
                            n_phase = btlv_pkg::PH_LEN_FIRST;
                        end
                    end
                    btlv_pkg::PH_LEN_FIRST: begin
                        if (i_data_byte[7]) begin
                            if (i_data_byte[6:0] > btlv_pkg::LEN_MAX_BYTES) begin
                                err_v    = 1'b1;
                                err_code = btlv_pkg::ERR_LEN_FORM;
                            end else if (i_data_byte[6:0] == 7'd0) begin
                                hdr_fire = 1'b1;
                            end else begin
                                n_len      = '0;
                                n_len_left = i_data_byte[1:0];
                                n_phase    = btlv_pkg::PH_LEN_MORE;
                            end
                        end else begin
                            hdr_fire = 1'b1;
                            hdr_len  = LEN_W'(i_data_byte);
                        end
                    end
                    btlv_pkg::PH_LEN_MORE: begin
                        n_len      = {r_len[15:0], i_data_byte};
                        n_len_left = r_len_left - 2'd1;
                        if (n_len_left == 2'd0) begin
                            hdr_fire = 1'b1;
                            hdr_len  = n_len;
                        end
                    end
                    btlv_pkg::PH_VALUE: begin
                        n_vbl                 = r_vbl - LEN_W'(1);
                        res.kind              = btlv_pkg::KIND_VALUE;
                        res.nest_level        = r_dp;
                        res.tag_value         = r_tag;
                        res.value_length      = r_len;
                        res.value_byte        = i_data_byte;
                        res.last_value_byte   = (n_vbl == '0);
                        res_v                 = 1'b1;
                        if (n_vbl == '0) begin
                            n_phase   = btlv_pkg::PH_TAG_FIRST;
                            close_req = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = btlv_pkg::PH_TAG_FIRST;
                    end
                endcase

                // Header complete: check against parent and depth limit
                if (hdr_fire) begin
                    if (has_parent && hdr_len > top_dec) begin
                        err_v    = 1'b1;
                        err_code = btlv_pkg::ERR_OVERRUN;
                    end else if (r_cons && hdr_len != '0 && r_dp >= 4'(MAX_DEPTH)) begin
                        err_v    = 1'b1;
                        err_code = btlv_pkg::ERR_DEPTH;
                    end else begin
                        top_new            = top_dec - hdr_len;
                        n_len              = hdr_len;
                        res.kind           = btlv_pkg::KIND_HEADER;
                        res.nest_level     = r_dp;
                        res.tag_value      = r_tag;
                        res.is_constructed = r_cons;
                        res.value_length   = hdr_len;
                        res_v              = 1'b1;
                        if (r_cons && hdr_len != '0) begin
                            wr_push = 1'b1;
                            n_dp    = r_dp + 4'd1;
                            n_phase = btlv_pkg::PH_TAG_FIRST;
                        end else if (hdr_len != '0) begin
                            n_vbl   = hdr_len;
                            n_phase = btlv_pkg::PH_VALUE;
                        end else begin
                            n_phase   = btlv_pkg::PH_TAG_FIRST;
                            close_req = 1'b1;
                        end
                    end
                end

                // Close every finished enclosing element: new depth is one
                // above the highest open entry that still has bytes left
                if (close_req) begin
                    for (int i = 0; i < MAX_DEPTH; i++) begin
                        nz = (IDX_W'(i) == top_idx) ? (top_new != '0) : (r_stack[i] != '0);
                        if (nz && 4'(i) < r_dp) begin
                            cdp = 4'(i + 1);
                        end
                    end
                    n_dp = cdp;
                end
            end

            // Errors replace the normal result and latch
            if (err_v) begin
                res     = btlv_pkg::make_error(r_dp, err_code);
                res_v   = 1'b1;
                n_err   = 1'b1;
                wr_top  = 1'b0;
                wr_push = 1'b0;
            end else if (i_end_of_stream &&
                         (n_phase != btlv_pkg::PH_TAG_FIRST || n_dp != 4'd0)) begin
                res   = btlv_pkg::make_error(n_dp, btlv_pkg::ERR_TRUNCATED);
                res_v = 1'b1;
            end
        end

        // End of stream returns the parser to its reset state
        if (i_accept && i_end_of_stream) begin
            n_phase    = btlv_pkg::PH_TAG_FIRST;
            n_tag      = '0;
            n_tag_cnt  = 4'd0;
            n_cons     = 1'b0;
            n_len      = '0;
            n_len_left = 2'd0;
            n_vbl      = '0;
            n_dp       = 4'd0;
            n_err      = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= btlv_pkg::PH_TAG_FIRST;
            r_tag_cnt  <= 4'd0;
            r_len_left <= 2'd0;
            r_dp       <= 4'd0;
            r_err      <= 1'b0;
            r_cons     <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_tag_cnt  <= n_tag_cnt;
            r_len_left <= n_len_left;
            r_dp       <= n_dp;
            r_err      <= n_err;
            r_cons     <= n_cons;
        end
    end

    // Accumulators
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_tag <= n_tag;
            r_len <= n_len;
            r_vbl <= n_vbl;
        end
    end

    // Stack writes: decrement of the top, push of a new entry
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_DEPTH; i++) begin
            if (wr_top && IDX_W'(i) == top_idx) begin
                r_stack[i] <= top_new;
            end
            if (wr_push && IDX_W'(i) == push_idx) begin
                r_stack[i] <= hdr_len;
            end
        end
    end

    assign o_res_valid = res_v;
    assign o_res       = res;

endmodule

// File: src/btlv_out_buf.sv
// Result register with a skid entry so input and output stall independently.
module btlv_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_res_valid,
    input  btlv_pkg::t_result   i_res,
    output logic                o_space,
    output logic                o_valid,
    output btlv_pkg::t_result   o_res,
    input  logic                i_ready
);

    logic               r_main_v;
    logic               r_skid_v;
    btlv_pkg::t_result  r_main;
    btlv_pkg::t_result  r_skid;
    logic               load_main;

    // Main register is free when empty or draining this cycle
    assign load_main = !r_main_v || i_ready;
    assign o_space   = !r_skid_v;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (load_main) begin
            r_main_v <= r_skid_v || i_res_valid;
            r_skid_v <= 1'b0;
        end else if (i_res_valid) begin
            r_skid_v <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (load_main) begin
            r_main <= r_skid_v ? r_skid : i_res;
        end else if (i_res_valid) begin
            r_skid <= i_res;
        end
    end

    assign o_valid = r_main_v;
    assign o_res   = r_main;

endmodule

// File: src/ber_tlv_stream_parser.sv
// Top level of the BER-TLV stream parser.
//
// i_tlv takes one raw stream byte per beat; end_of_stream marks the last byte
// of a top-level stream, after which the parser is back in its reset state.
// o_res gives at most one beat per input byte: an element header (level, tag,
// constructed flag, length), one beat per primitive value byte with a last
// flag, or an error. After an error the stream is dropped silently until its
// end_of_stream byte.
// Each result is registered in the result register, or in the skid entry while
// the receiver stalls. One byte is taken per cycle while i_tlv.ready is high:
// the decode of a byte and the stack-top update are a single register-to-register
// step; closing finished parents is a priority search over the stack in it.
// o_res is driven from a result register backed by one skid entry; while the
// receiver stalls, input keeps flowing until the skid entry holds a result,
// and i_tlv.ready drops only then.
// Reset (i_rst_n low, synchronous) empties the output and puts the parser in
// the state that expects the first tag byte of a new stream.
module ber_tlv_stream_parser #(
    parameter int MAX_DEPTH    = btlv_pkg::MAX_DEPTH_DEF,
    parameter int MAX_TAG_SCAN = btlv_pkg::MAX_TAG_SCAN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    btlv_in_if.sink     i_tlv,
    btlv_out_if.source  o_res
);

    logic               accept;
    logic               space;
    logic               core_v;
    btlv_pkg::t_result  core_res;
    btlv_pkg::t_result  out_res;
    logic               out_v;

    // Input handshake
    assign i_tlv.ready = space;
    assign accept      = i_tlv.valid && space;

    btlv_core #(
        .MAX_DEPTH    (MAX_DEPTH),
        .MAX_TAG_SCAN (MAX_TAG_SCAN)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data_byte     (i_tlv.data_byte),
        .i_end_of_stream (i_tlv.end_of_stream),
        .o_res_valid     (core_v),
        .o_res           (core_res)
    );

    btlv_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (core_v),
        .i_res       (core_res),
        .o_space     (space),
        .o_valid     (out_v),
        .o_res       (out_res),
        .i_ready     (o_res.ready)
    );

    // Output beat
    assign o_res.valid           = out_v;
    assign o_res.kind            = out_res.kind;
    assign o_res.nest_level      = out_res.nest_level;
    assign o_res.tag_value       = out_res.tag_value;
    assign o_res.is_constructed  = out_res.is_constructed;
    assign o_res.value_length    = out_res.value_length;
    assign o_res.value_byte      = out_res.value_byte;
    assign o_res.last_value_byte = out_res.last_value_byte;
    assign o_res.error_code      = out_res.error_code;

endmodule
